FILE: rtl/core/filtered_audio_rms_level_detector_macros.svh
// Assertion macros used by the level detector
`ifndef FILTERED_AUDIO_RMS_LEVEL_DETECTOR_MACROS_SVH
`define FILTERED_AUDIO_RMS_LEVEL_DETECTOR_MACROS_SVH
// implication checked on every edge outside reset
`define FARLD_ASSERT_IMP(label, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("check failed");
// next-cycle implication
`define FARLD_ASSERT_NXT(label, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("check failed");
`endif

FILE: rtl/core/farld_pkg.sv
// Package: constants and types for the level detector
`default_nettype none
package farld_pkg;
	localparam int MAX_BLOCK_FRAMES = 256;
	localparam int COEF_FRAC_BITS   = 16;
	localparam int SUM_W            = 41;
	localparam int CNT_W            = 13;
	localparam logic [15:0] HP_COEF_RST = 16'd61866;
	localparam logic [15:0] LP_COEF_RST = 16'd40042;
	localparam logic [7:0]  GAIN_RST    = 8'd64;
	localparam logic [15:0] THR_RST     = 16'd500;
	localparam logic [15:0] SCALE_RST   = 16'd150;
	localparam logic [7:0]  BMAX_RST    = 8'd50;
	localparam logic [2:0] REG_HP = 3'd0;
	localparam logic [2:0] REG_LP = 3'd1;
	localparam logic [2:0] REG_GAIN = 3'd2;
	localparam logic [2:0] REG_THR = 3'd3;
	localparam logic [2:0] REG_SCALE = 3'd4;
	localparam logic [2:0] REG_BMAX = 3'd5;
	typedef struct packed {
		logic [15:0] hp_coef;
		logic [15:0] lp_coef;
		logic [7:0]  gain;
		logic [15:0] thr;
		logic [15:0] scale;
		logic [7:0]  bmax;
	} cfg_t;
endpackage
`default_nettype wire

FILE: rtl/core/filtered_audio_rms_level_detector.sv
// A plain frame holds in_ready low through four 24-bit shift-and-add multiplies in one
// shared unit, followed by the accumulate state.
// A last frame then runs a 41-bit division and a 21-bit root, and then the bar steps
// (up to bar_max subtractions) before out_valid rises.
// Throughput: one frame at a time; in_ready is low from transfer until the block is idle.
// Reset clears filter state, accumulator, count and sets registers to defaults.
`default_nettype none
`include "filtered_audio_rms_level_detector_macros.svh"
module filtered_audio_rms_level_detector #(
	parameter int MAX_BLOCK_FRAMES = farld_pkg::MAX_BLOCK_FRAMES,
	parameter int COEF_FRAC_BITS = farld_pkg::COEF_FRAC_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] left_sample,
	input  wire logic signed [31:0] right_sample,
	input  wire logic               last_of_block,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [15:0]             level_rms,
	output logic [7:0]              bar_length,
	output logic                    speech_detected
);
	localparam int SW = farld_pkg::SUM_W;
	localparam int NW = farld_pkg::CNT_W;
	localparam int MW = 48;
	localparam int BW = 24;
	localparam logic signed [MW-1:0] S32MAX = MW'(64'sh7FFFFFFF);
	localparam logic signed [MW-1:0] S32MIN = -MW'(64'sh80000000);

	typedef enum logic [3:0] {
		ST_IDLE, ST_HP, ST_HPW, ST_LP, ST_LPW, ST_G1, ST_G1W, ST_G2, ST_G2W,
		ST_ACC, ST_DIV, ST_DIVW, ST_SQW, ST_BAR, ST_BARW, ST_OUT
	} state_t;
	state_t state_q;
	farld_pkg::cfg_t cfg_q;

	logic signed [31:0] hp_in_q, hp_out_q, lp_out_q, x_q;
	logic [SW-1:0] sum_q;
	logic [NW-1:0] cnt_q;
	logic last_q;
	logic signed [MW-1:0] opa_q, t_q;
	logic [BW-1:0] opb_q;
	logic mstart_q, dstart_q, sstart_q;
	logic [SW-1:0] dnum_q;
	logic [NW-1:0] dden_q;
	logic [15:0] rms_q;
	logic [15:0] val_q;
	logic neg_q;

	logic mdone, ddone, sdone;
	logic signed [MW+BW-1:0] mprod;
	logic [SW-1:0] dquo;
	logic [20:0] sroot;

	farld_serial_mul #(.AW(MW), .BW(BW)) u_mul (
		.clk, .arst_n, .start(mstart_q), .a(opa_q), .b(opb_q), .done(mdone), .prod(mprod));
	farld_serial_div #(.NW(SW), .DW(NW)) u_div (
		.clk, .arst_n, .start(dstart_q), .num(dnum_q), .den(dden_q), .done(ddone), .quo(dquo));
	farld_serial_sqrt #(.NW(SW + 1)) u_sqrt (
		.clk, .arst_n, .start(sstart_q), .num({1'b0, dquo}), .done(sdone), .root(sroot));

	// selection of the louder channel
	logic [32:0] mag_l, mag_r;
	logic signed [31:0] pick;
	always_comb begin
		mag_l = left_sample[31] ? 33'(-{left_sample[31], left_sample}) : 33'(left_sample);
		mag_r = right_sample[31] ? 33'(-{right_sample[31], right_sample}) : 33'(right_sample);
		pick = (mag_l > mag_r) ? left_sample : right_sample;
	end

	logic signed [MW-1:0] shifted, sat;
	always_comb begin
		shifted = MW'(mprod >>> COEF_FRAC_BITS);
		sat = shifted;
	end
	function automatic logic signed [31:0] sat32(input logic signed [MW-1:0] v);
		if (v > S32MAX) return 32'sh7FFFFFFF;
		if (v < S32MIN) return 32'sh80000000;
		return v[31:0];
	endfunction

	logic [31:0] sq_full;
	logic [SW:0] sum_next;
	always_comb begin
		sq_full = 32'(val_q) * 32'(val_q);
		sum_next = {1'b0, sum_q} + (SW+1)'(sq_full);
	end

	assign pready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	always_comb begin
		unique case (paddr[4:2])
			farld_pkg::REG_HP: prdata = 32'(cfg_q.hp_coef);
			farld_pkg::REG_LP: prdata = 32'(cfg_q.lp_coef);
			farld_pkg::REG_GAIN: prdata = 32'(cfg_q.gain);
			farld_pkg::REG_THR: prdata = 32'(cfg_q.thr);
			farld_pkg::REG_SCALE: prdata = 32'(cfg_q.scale);
			farld_pkg::REG_BMAX: prdata = 32'(cfg_q.bmax);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{farld_pkg::HP_COEF_RST, farld_pkg::LP_COEF_RST, farld_pkg::GAIN_RST,
				farld_pkg::THR_RST, farld_pkg::SCALE_RST, farld_pkg::BMAX_RST};
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				farld_pkg::REG_HP: cfg_q.hp_coef <= pwdata[15:0];
				farld_pkg::REG_LP: cfg_q.lp_coef <= pwdata[15:0];
				farld_pkg::REG_GAIN: cfg_q.gain <= pwdata[7:0];
				farld_pkg::REG_THR: cfg_q.thr <= pwdata[15:0];
				farld_pkg::REG_SCALE: cfg_q.scale <= pwdata[15:0];
				farld_pkg::REG_BMAX: cfg_q.bmax <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hp_in_q <= '0;
			hp_out_q <= '0;
			lp_out_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			out_valid <= 1'b0;
			mstart_q <= 1'b0;
			dstart_q <= 1'b0;
			sstart_q <= 1'b0;
		end else begin
			mstart_q <= 1'b0;
			dstart_q <= 1'b0;
			sstart_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					x_q <= 32'(pick >>> 8);
					last_q <= last_of_block;
					state_q <= ST_HP;
				end
				ST_HP: begin
					opa_q <= MW'(hp_out_q) + MW'(x_q) - MW'(hp_in_q);
					opb_q <= BW'(cfg_q.hp_coef);
					hp_in_q <= x_q;
					mstart_q <= 1'b1;
					state_q <= ST_HPW;
				end
				ST_HPW: if (mdone) begin
					hp_out_q <= sat32(sat);
					state_q <= ST_LP;
				end
				ST_LP: begin
					opa_q <= MW'(hp_out_q) - MW'(lp_out_q);
					opb_q <= BW'(cfg_q.lp_coef);
					mstart_q <= 1'b1;
					state_q <= ST_LPW;
				end
				ST_LPW: if (mdone) begin
					lp_out_q <= sat32(MW'(lp_out_q) + shifted);
					state_q <= ST_G1;
				end
				ST_G1: begin
					opa_q <= MW'(lp_out_q);
					opb_q <= BW'(cfg_q.gain);
					mstart_q <= 1'b1;
					state_q <= ST_G1W;
				end
				ST_G1W: if (mdone) begin
					t_q <= MW'(mprod);
					state_q <= ST_G2;
				end
				ST_G2: begin
					// multiply the magnitude so truncation goes toward zero
					neg_q <= t_q[MW-1];
					opa_q <= t_q[MW-1] ? -t_q : t_q;
					opb_q <= BW'(32767);
					mstart_q <= 1'b1;
					state_q <= ST_G2W;
				end
				ST_G2W: if (mdone) begin
					if (mprod[MW+BW-1:23] > (MW+BW-23)'(32767))
						val_q <= neg_q ? 16'd32767 : 16'd32767;
					else
						val_q <= 16'(mprod[38:23]);
					if (neg_q && mprod[MW+BW-1:23] >= (MW+BW-23)'(32768))
						val_q <= 16'd32768;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (32'(cnt_q) < MAX_BLOCK_FRAMES) begin
						sum_q <= sum_next[SW] ? '1 : sum_next[SW-1:0];
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= last_q ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					dnum_q <= sum_q;
					dden_q <= cnt_q;
					dstart_q <= 1'b1;
					state_q <= ST_DIVW;
				end
				ST_DIVW: if (ddone) begin
					sstart_q <= 1'b1;
					state_q <= ST_SQW;
				end
				ST_SQW: if (sdone) begin
					rms_q <= 16'(sroot);
					state_q <= ST_BAR;
				end
				ST_BAR: begin
					dnum_q <= SW'(rms_q);
					dden_q <= NW'(0);
					state_q <= ST_BARW;
					opa_q <= '0;
				end
				ST_BARW: begin
					// bar = rms / scale by repeated subtraction, capped at bmax
					if (cfg_q.scale == 16'd0 || opa_q[7:0] == cfg_q.bmax ||
							MW'(dnum_q) < MW'(cfg_q.scale)) begin
						level_rms <= rms_q;
						bar_length <= opa_q[7:0];
						speech_detected <= rms_q > cfg_q.thr;
						if (cfg_q.scale == 16'd0) bar_length <= cfg_q.bmax;
						out_valid <= 1'b1;
						sum_q <= '0;
						cnt_q <= '0;
						state_q <= ST_OUT;
					end else begin
						dnum_q <= dnum_q - SW'(cfg_q.scale);
						opa_q <= opa_q + 1'b1;
					end
				end
				ST_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`FARLD_ASSERT_IMP(a_ready_idle, arst_n, in_ready, !out_valid)
	`FARLD_ASSERT_NXT(a_out_hold, arst_n, out_valid && !out_ready, out_valid && $stable(level_rms))
	`FARLD_ASSERT_IMP(a_cnt_cap, arst_n, 1'b1, 32'(cnt_q) <= MAX_BLOCK_FRAMES)
endmodule
`default_nettype wire

FILE: rtl/core/farld_serial_mul.sv
// Shift-and-add multiplier: signed 48-bit multiplicand, unsigned multiplier, one bit a cycle
`default_nettype none
module farld_serial_mul #(
	parameter int AW = 48,
	parameter int BW = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [AW-1:0] a,
	input  wire logic [BW-1:0]        b,
	output logic                      done,
	output logic signed [AW+BW-1:0]   prod
);
	localparam int CW = $clog2(BW + 1);
	logic signed [AW+BW-1:0] acc_q, mcand_q;
	logic [BW-1:0] mplier_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				acc_q <= '0;
				mcand_q <= (AW+BW)'(a);
				mplier_q <= b;
			end else if (busy_q) begin
				if (mplier_q[0]) acc_q <= acc_q + mcand_q;
				mcand_q <= mcand_q <<< 1;
				mplier_q <= mplier_q >> 1;
				if (cnt_q == CW'(BW - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end
	always_comb prod = acc_q;
endmodule
`default_nettype wire

FILE: rtl/core/farld_serial_div.sv
// Restoring divider, one quotient bit a cycle
`default_nettype none
module farld_serial_div #(
	parameter int NW = 41,
	parameter int DW = 13
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] q_q;
	logic [DW:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [DW:0] trial;
	always_comb trial = {rem_q[DW-1:0], q_q[NW-1]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				q_q <= num;
				rem_q <= '0;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (trial >= {1'b0, den}) begin
					rem_q <= trial - {1'b0, den};
					q_q <= {q_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					q_q <= {q_q[NW-2:0], 1'b0};
				end
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end
	always_comb quo = q_q;
endmodule
`default_nettype wire

FILE: rtl/core/farld_serial_sqrt.sv
// Bit-pair integer square root, one root bit a cycle
`default_nettype none
module farld_serial_sqrt #(
	parameter int NW = 42
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [NW-1:0]   num,
	output logic                 done,
	output logic [NW/2-1:0]      root
);
	localparam int RW = NW / 2;
	localparam int CW = $clog2(RW + 1);
	logic [NW-1:0] n_q;
	logic [RW+1:0] rem_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [RW+1:0] trial, sub;
	always_comb begin
		trial = {rem_q[RW-1:0], n_q[NW-1:NW-2]};
		sub = {r_q, 2'b01};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q <= num;
				rem_q <= '0;
				r_q <= '0;
				cnt_q <= '0;
			end else if (busy_q) begin
				n_q <= n_q << 2;
				if (trial >= sub) begin
					rem_q <= trial - sub;
					r_q <= {r_q[RW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					r_q <= {r_q[RW-2:0], 1'b0};
				end
				if (cnt_q == CW'(RW - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end
	always_comb root = r_q;
endmodule
`default_nettype wire
